// File: hw/rtl/lcdnws_pkg.sv
// lcdnws_pkg: shared types, constants and the init command table for the
// 4-bit character LCD write sequencer. No dependencies.
package lcdnws_pkg;

  localparam int INIT_TABLE_LEN = 11;
  localparam int INIT_STEPS_DEF = 11;
  localparam int STEP_W = 4;
  localparam int HOLD_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [1:0] CMD_COMMAND = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_GAP = 2'd2;

  localparam logic [CFG_W-1:0] ENABLE_HOLD_RST = 16'd200;
  localparam logic [CFG_W-1:0] SETTLE_HOLD_RST = 16'd400;
  localparam logic [CFG_W-1:0] COMMAND_GAP_RST = 16'd5000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0]        port_byte;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              emit;
    logic              init_mode;
    logic [STEP_W-1:0] step;
    logic [1:0]        phase;
    logic              last;
    logic              gap;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_load;
  } dp_stat_t;

  function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h03;
      4'd1:    b = 8'h03;
      4'd2:    b = 8'h03;
      4'd3:    b = 8'h02;
      4'd4:    b = 8'h28;
      4'd5:    b = 8'h02;
      4'd6:    b = 8'h08;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h0C;
      4'd9:    b = 8'h00;
      4'd10:   b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/lcdnws_ctrl.sv
// lcdnws_ctrl: sequencing state machine; walks nibble phases and init steps.
// Depends on lcdnws_pkg.
module lcdnws_ctrl import lcdnws_pkg::*; #(
  parameter int INIT_STEPS = INIT_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_cmd,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  localparam int INIT_COUNT = (INIT_STEPS < 1) ? 1 :
                              (INIT_STEPS > INIT_TABLE_LEN) ? INIT_TABLE_LEN : INIT_STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(INIT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [1:0]        phase, phase_next;
  logic [STEP_W-1:0] step, step_next;
  logic              init_mode, init_mode_next;
  logic              accept, last_write, emit;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign last_write = (phase == 2'd3) && (!init_mode || step == LAST_STEP);
  assign emit = (state == ST_RUN) && stat.can_load;

  always_comb begin
    state_next = state;
    phase_next = phase;
    step_next = step;
    init_mode_next = init_mode;
    case (state)
      ST_IDLE: begin
        if (accept && (in_cmd inside {CMD_COMMAND, CMD_DATA, CMD_INIT})) begin
          state_next = ST_RUN;
          phase_next = 2'd0;
          step_next = '0;
          init_mode_next = (in_cmd == CMD_INIT);
        end
      end
      ST_RUN: begin
        if (emit) begin
          if (last_write) begin
            state_next = ST_IDLE;
          end else begin
            phase_next = phase + 2'd1;
            if (phase == 2'd3) begin
              step_next = step + STEP_W'(1);
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 2'd0;
      step <= '0;
      init_mode <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      step <= step_next;
      init_mode <= init_mode_next;
    end
  end

  always_comb begin
    dcmd.capture = accept;
    dcmd.emit = emit;
    dcmd.init_mode = init_mode;
    dcmd.step = step;
    dcmd.phase = phase;
    dcmd.last = last_write;
    dcmd.gap = init_mode && (phase == 2'd3);
  end

endmodule

// File: hw/rtl/lcdnws_dp.sv
// lcdnws_dp: hold-time registers, captured byte, port byte builder and
// output register. Depends on lcdnws_pkg.
module lcdnws_dp import lcdnws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_t                  in_data,
  input  dp_cmd_t              dcmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  logic [CFG_W-1:0]  enable_hold, settle_hold, command_gap;
  logic [7:0]        value_q;
  logic              rs_q;
  logic [7:0]        cur_byte;
  logic [3:0]        nibble;
  logic              rs;
  logic [HOLD_W-1:0] hold;
  out_t              wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_hold <= ENABLE_HOLD_RST;
      settle_hold <= SETTLE_HOLD_RST;
      command_gap <= COMMAND_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE_HOLD: enable_hold <= cfg_data;
        REG_SETTLE_HOLD: settle_hold <= cfg_data;
        REG_COMMAND_GAP: command_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.capture) begin
      value_q <= in_data.value;
      rs_q <= in_data.cmd[0];
    end
  end

  always_comb begin
    cur_byte = dcmd.init_mode ? init_cmd(dcmd.step) : value_q;
    rs = dcmd.init_mode ? 1'b0 : rs_q;
    nibble = dcmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
    // odd phases drop EN and wait the settle time, plus the command gap after each init command
    if (dcmd.phase[0]) begin
      hold = {1'b0, settle_hold} + (dcmd.gap ? {1'b0, command_gap} : '0);
    end else begin
      hold = {1'b0, enable_hold};
    end
    wr.port_byte = {nibble, ~dcmd.phase[0], rs, 2'b00};
    wr.hold_us = hold;
    wr.last = dcmd.last;
  end

  assign stat.can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.emit) begin
      out_data <= wr;
    end
  end

endmodule

// File: hw/rtl/lcdnws_checker.sv
// lcdnws_checker: port-level assertions for the LCD write sequencer, bound
// to the top level. Depends on lcdnws_pkg.
module lcdnws_checker import lcdnws_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled write changed");

  a_low_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.port_byte[1:0] == 2'b00)
    else $error("port byte low bits set");

  a_en_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.port_byte[3] |-> !out_data.last)
    else $error("enable-high write flagged last");

  // when a new request can be taken only the final write may still wait
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_data.last)
    else $error("idle with unfinished writes");

endmodule

bind lcd_nibble_write_sequencer_core lcdnws_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

// File: hw/rtl/lcd_nibble_write_sequencer_core.sv
// lcd_nibble_write_sequencer_core: top level of the 4-bit LCD write sequencer.
// Depends on lcdnws_pkg, lcdnws_ctrl and lcdnws_dp.
//
// Usage: in_data carries cmd (command byte, data byte, init) and value;
// each request is accepted when in_valid and in_ready are high. Every port
// write leaves on out_data (port byte, hold time, last flag) under
// out_valid/out_ready. A byte request gives four writes, an init request
// four writes per init command (44 for the full list); cmd 3 is taken and
// gives nothing. Writes leave one per cycle from a single output register
// while the receiver takes them; the first is loaded after the controller
// has entered its run state. INIT_STEPS is clamped to 1..11. in_ready
// stays low while a request's writes are loaded, so no new request is
// taken before then; it returns high once the final write is loaded, while
// that write may still wait in the output register.
// If the receiver stalls, the write holds and sequencing pauses.
// Hold-time registers are written through cfg_we/cfg_index/cfg_data while
// idle; the user must keep to this, the block itself leaves it unenforced.
// Synchronous reset empties the output and restores the hold times.
module lcd_nibble_write_sequencer_core import lcdnws_pkg::*; #(
  parameter int INIT_STEPS = INIT_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  lcdnws_ctrl #(
    .INIT_STEPS(INIT_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_data.cmd),
    .stat(stat),
    .dcmd(dcmd)
  );

  lcdnws_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_data(in_data),
    .dcmd(dcmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
